// ===== hdl/fpm3_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fpm3_pkg;

    localparam int unsigned DIM   = 3;
    localparam int unsigned CELLS = 9;

    localparam logic SEL_LEFT  = 1'b0;
    localparam logic SEL_RIGHT = 1'b1;

    localparam logic [1:0] LAST_IDX = 2'(DIM - 1);

    typedef logic [3:0]  t_addr;
    typedef logic [31:0] t_word;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WAIT,
        ST_RUN,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic       valid;
        logic [1:0] k;
        logic [1:0] row;
        logic [1:0] col;
        logic       last;
    } t_mac_ctl;

    typedef struct packed {
        logic done;
        logic out_free;
    } t_mac_sts;

endpackage

`default_nettype wire

// ===== hdl/fpm3_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface fpm3_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;
    logic               matrix_select;
    logic [3:0]         position;
    logic               compute;

    modport source (output valid, value, matrix_select, position, compute, input ready);
    modport sink   (input valid, value, matrix_select, position, compute, output ready);
endinterface

`default_nettype wire

// ===== hdl/fpm3_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface fpm3_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] product;
    logic [1:0]         out_row;
    logic [1:0]         out_col;
    logic               last;

    modport source (output valid, product, out_row, out_col, last, input ready);
    modport sink   (input valid, product, out_row, out_col, last, output ready);
endinterface

`default_nettype wire

// ===== hdl/fpm3_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fpm3_ram
    import fpm3_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_we,
    input  wire t_addr i_waddr,
    input  wire t_word i_wdata,
    input  wire t_addr i_raddr,
    output t_word      o_rdata
);

    t_word r_mem [CELLS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== hdl/fpm3_mac.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fpm3_mac
    import fpm3_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 12
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_mac_ctl i_ctl,
    input  wire t_word    i_a,
    input  wire t_word    i_b,
    output t_mac_sts      o_sts,
    fpm3_out_if.source    o_out
);

    t_mac_ctl           r_s1_ctl;
    t_mac_ctl           r_s2_ctl;
    logic signed [63:0] r_prod;
    logic [63:0]        r_acc;
    logic [63:0]        n_sum;
    logic               r_out_valid;
    t_word              r_product;
    logic [1:0]         r_row;
    logic [1:0]         r_col;
    logic               r_last;
    logic               s2_final;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl <= '0;
            r_s2_ctl <= '0;
        end else begin
            r_s1_ctl <= i_ctl;
            r_s2_ctl <= r_s1_ctl;
        end
    end

    // memory data lines up with stage one control
    always_ff @(posedge i_clk) begin
        if (r_s1_ctl.valid) begin
            r_prod <= signed'(i_a) * signed'(i_b);
        end
    end

    always_comb begin
        n_sum    = ((r_s2_ctl.k == 2'd0) ? 64'd0 : r_acc) + 64'(r_prod);
        s2_final = r_s2_ctl.valid && (r_s2_ctl.k == LAST_IDX);
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_ctl.valid && !s2_final) begin
            r_acc <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_final) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_final) begin
            r_product <= n_sum[FRAC_BITS +: 32];
            r_row     <= r_s2_ctl.row;
            r_col     <= r_s2_ctl.col;
            r_last    <= r_s2_ctl.last;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.product = signed'(r_product);
    assign o_out.out_row = r_row;
    assign o_out.out_col = r_col;
    assign o_out.last    = r_last;

    assign o_sts.done     = s2_final;
    assign o_sts.out_free = !r_out_valid || o_out.ready;

endmodule

`default_nettype wire

// ===== hdl/fixed_point_matrix3_multiply.sv =====
// fixed_point_matrix3_multiply: product of two 3x3 signed Q20.12 matrices
//
// input channel i_in: each item writes value into the left (matrix_select 0)
// or right (matrix_select 1) matrix at position row*3+col; positions 9..15
// store nothing. an item with compute set stores first, then starts the
// product. both matrices sit in 9-entry synchronous memories.
// output channel o_out: nine result items in row-major order, each the
// three-term dot product shifted right by FRAC_BITS and kept to 32 bits,
// last set on the ninth.
// sequencing: load items are taken while i_in.ready is high. for a compute item
// each result goes through wait, three memory reads, multiply and accumulate,
// and the receiver can stall the sequence. i_in.ready is low from the compute
// item until the last result is loaded.
// when the receiver stalls, the finished result holds in the output register
// and the next dot product does not start until that register frees up.
// reset clears the sequencer and the output valid; matrix contents are
// undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module fixed_point_matrix3_multiply
    import fpm3_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 12
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    fpm3_in_if.sink    i_in,
    fpm3_out_if.source o_out
);

    t_state     r_state;
    t_state     n_state;
    logic [1:0] r_row;
    logic [1:0] n_row;
    logic [1:0] r_col;
    logic [1:0] n_col;
    logic [1:0] r_k;
    logic [1:0] n_k;
    t_mac_ctl   mac_ctl;
    t_mac_sts   mac_sts;
    logic       accept;
    logic       pos_ok;
    t_addr      left_raddr;
    t_addr      right_raddr;
    t_word      left_rdata;
    t_word      right_rdata;

    assign accept = i_in.valid && i_in.ready;
    assign pos_ok = (i_in.position < 4'(CELLS));

    assign left_raddr  = t_addr'({r_row, 1'b0}) + t_addr'(r_row) + t_addr'(r_k);
    assign right_raddr = t_addr'({r_k, 1'b0}) + t_addr'(r_k) + t_addr'(r_col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_row   <= '0;
            r_col   <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_col   <= n_col;
            r_k     <= n_k;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_row         = r_row;
        n_col         = r_col;
        n_k           = r_k;
        i_in.ready    = 1'b0;
        mac_ctl.valid = 1'b0;
        mac_ctl.k     = r_k;
        mac_ctl.row   = r_row;
        mac_ctl.col   = r_col;
        mac_ctl.last  = (r_row == LAST_IDX) && (r_col == LAST_IDX);
        unique case (r_state)
            ST_IDLE: begin
                i_in.ready = 1'b1;
                if (accept && i_in.compute) begin
                    n_state = ST_WAIT;
                    n_row   = '0;
                    n_col   = '0;
                end
            end
            ST_WAIT: begin
                if (mac_sts.out_free) begin
                    n_state = ST_RUN;
                    n_k     = '0;
                end
            end
            ST_RUN: begin
                mac_ctl.valid = 1'b1;
                n_k           = r_k + 2'd1;
                if (r_k == LAST_IDX) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (mac_sts.done) begin
                    if (mac_ctl.last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_WAIT;
                        if (r_col == LAST_IDX) begin
                            n_col = '0;
                            n_row = r_row + 2'd1;
                        end else begin
                            n_col = r_col + 2'd1;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    fpm3_ram u_left (
        .i_clk   (i_clk),
        .i_we    (accept && pos_ok && (i_in.matrix_select == SEL_LEFT)),
        .i_waddr (i_in.position),
        .i_wdata (t_word'(i_in.value)),
        .i_raddr (left_raddr),
        .o_rdata (left_rdata)
    );

    fpm3_ram u_right (
        .i_clk   (i_clk),
        .i_we    (accept && pos_ok && (i_in.matrix_select == SEL_RIGHT)),
        .i_waddr (i_in.position),
        .i_wdata (t_word'(i_in.value)),
        .i_raddr (right_raddr),
        .o_rdata (right_rdata)
    );

    fpm3_mac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .i_a     (left_rdata),
        .i_b     (right_rdata),
        .o_sts   (mac_sts),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

// ===== hdl/fpm3_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fpm3_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [31:0] i_product,
    input wire logic [1:0]  i_out_row,
    input wire logic [1:0]  i_out_col,
    input wire logic        i_last
);

    // stalled result item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_product)
            && $stable(i_out_row) && $stable(i_out_col) && $stable(i_last))
        else $error("stalled result item changed");

    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_last |-> (i_out_row == 2'd2) && (i_out_col == 2'd2))
        else $error("last flag away from bottom right element");

    // no input item while a product is partly delivered
    a_busy_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_last |-> !i_in_ready)
        else $error("input ready during product output");

    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_last |=> !i_in_ready)
        else $error("input ready before last result item");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind fixed_point_matrix3_multiply fpm3_checker u_fpm3_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_product   (o_out.product),
    .i_out_row   (o_out.out_row),
    .i_out_col   (o_out.out_col),
    .i_last      (o_out.last)
);

`default_nettype wire
